>>> sv/assert_macros.svh
// Assertion macros used by the checker's top-level RTL file.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent on one edge implies the consequent on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent implies the consequent on the same edge.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The expression must never hold.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

>>> sv/spv_ep_pkg.sv
// Shared types and constants of the SPIR-V entry point checker.
// No dependencies; imported by every module of the block.
package spv_ep_pkg;

	localparam int unsigned MAX_WORDS  = 4194304;
	localparam int unsigned NAME_BYTES = 32;

	localparam int unsigned WORD_POS_W = $clog2(MAX_WORDS + 2);
	localparam int unsigned CHAR_W     = 6;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CHARS_REGS = 4;

	localparam logic [31:0] HEADER_MAGIC       = 32'h0723_0203;
	localparam logic [15:0] OPCODE_ENTRY_POINT = 16'd15;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_MODEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NAME_LENGTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NAME_CHARS_0   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NAME_CHARS_1   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NAME_CHARS_2   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NAME_CHARS_3   = 3'd5;

	typedef enum logic [1:0] {
		VERDICT_OK          = 2'd0,
		VERDICT_BAD_MODULE  = 2'd1,
		VERDICT_WRONG_ENTRY = 2'd2,
		VERDICT_WRONG_STAGE = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [31:0]                  expected_model;
		logic [CHAR_W-1:0]            name_length;
		logic [CHARS_REGS-1:0][63:0]  name_chars;
	} cfg_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} item_t;

	typedef struct packed {
		logic              done;
		logic              good;
		logic [CHAR_W-1:0] char_pos;
	} name_res_t;

	typedef struct packed {
		logic       at_start;
		logic [1:0] entry_count;
	} core_stat_t;

endpackage

>>> sv/spv_ep_name_cmp.sv
// Compares one name word of an entry point against the configured name.
// Depends on spv_ep_pkg; purely combinational, used by spv_ep_core.
module spv_ep_name_cmp import spv_ep_pkg::*; (
	input  logic [31:0]                 word,
	input  logic [CHAR_W-1:0]           char_pos,
	input  logic [CHAR_W-1:0]           name_length,
	input  logic [CHARS_REGS-1:0][63:0] name_chars,
	output name_res_t                   res
);

	logic [CHARS_REGS*64-1:0] flat_chars;

	assign flat_chars = name_chars;

	// Expected character at a position; positions past the stored name read as zero.
	function automatic logic [7:0] exp_char(input logic [CHAR_W-1:0] pos,
			input logic [CHARS_REGS*64-1:0] chars);
		logic [7:0] c;
		c = 8'h00;
		if (pos < CHAR_W'(NAME_BYTES))
			c = chars[{pos[4:0], 3'b000} +: 8];
		return c;
	endfunction

	// Walk the four bytes low first; the first terminator or mismatch decides.
	always_comb begin
		logic [7:0]        byte_v;
		logic [CHAR_W-1:0] cp;
		logic              done;
		logic              good;
		cp   = char_pos;
		done = 1'b0;
		good = 1'b0;
		for (int b = 0; b < 4; b++) begin
			byte_v = word[8*b +: 8];
			if (!done) begin
				if (byte_v == 8'h00) begin
					good = ((word & (32'hFFFF_FFFF << (8 * (b + 1)))) == 32'h0) &&
						(cp == name_length);
					done = 1'b1;
				end else if (cp >= name_length || byte_v != exp_char(cp, flat_chars)) begin
					good = 1'b0;
					done = 1'b1;
				end else begin
					cp = cp + 1'b1;
				end
			end
		end
		res.done     = done;
		res.good     = good;
		res.char_pos = cp;
	end

endmodule

>>> sv/spv_ep_cfg.sv
// Configuration register file of the checker.
// Depends on spv_ep_pkg; writes outside the register list are ignored.
module spv_ep_cfg import spv_ep_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register decode; cfg_ready is always high, so every write is taken when offered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_EXPECTED_MODEL: cfg_q.expected_model <= cfg_data[31:0];
				CFG_NAME_LENGTH:    cfg_q.name_length    <= cfg_data[CHAR_W-1:0];
				CFG_NAME_CHARS_0:   cfg_q.name_chars[0]  <= cfg_data;
				CFG_NAME_CHARS_1:   cfg_q.name_chars[1]  <= cfg_data;
				CFG_NAME_CHARS_2:   cfg_q.name_chars[2]  <= cfg_data;
				CFG_NAME_CHARS_3:   cfg_q.name_chars[3]  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> sv/spv_ep_core.sv
// Instruction walker and verdict logic of the checker, one word per step.
// Depends on spv_ep_pkg and spv_ep_name_cmp.
module spv_ep_core import spv_ep_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  item_t      item,
	input  cfg_t       cfg,
	output verdict_t   verdict,
	output core_stat_t stat
);

	logic [WORD_POS_W-1:0] word_pos_q, word_pos_n;
	logic                  magic_q, magic_n;
	logic [15:0]           left_q, left_n;
	logic [1:0]            offset_q, offset_n;
	logic                  is_entry_q, is_entry_n;
	logic [CHAR_W-1:0]     char_pos_q, char_pos_n;
	logic                  decided_q, decided_n;
	logic [1:0]            count_q, count_n;
	logic                  name_good_q, name_good_n;
	logic [31:0]           model_q, model_n;
	logic                  bad_q, bad_n;
	name_res_t             name_res;
	logic [15:0]           wc;

	spv_ep_name_cmp u_name_cmp (
		.word        (item.word),
		.char_pos    (char_pos_q),
		.name_length (cfg.name_length),
		.name_chars  (cfg.name_chars),
		.res         (name_res)
	);

	assign wc = item.word[31:16];

	// Next state for the word being taken.
	always_comb begin
		word_pos_n  = word_pos_q;
		magic_n     = magic_q;
		left_n      = left_q;
		offset_n    = offset_q;
		is_entry_n  = is_entry_q;
		char_pos_n  = char_pos_q;
		decided_n   = decided_q;
		count_n     = count_q;
		name_good_n = name_good_q;
		model_n     = model_q;
		bad_n       = bad_q;
		if (word_pos_q < WORD_POS_W'(MAX_WORDS)) begin
			if (word_pos_q == '0) begin
				magic_n = (item.word == HEADER_MAGIC);
			end else if (word_pos_q < WORD_POS_W'(5)) begin
				// Header words are skipped.
			end else if (left_q == 16'd0) begin
				// First word of an instruction.
				is_entry_n = 1'b0;
				if (wc == 16'd0) begin
					bad_n = 1'b1;
				end else begin
					left_n   = wc - 16'd1;
					offset_n = 2'd1;
					if (item.word[15:0] == OPCODE_ENTRY_POINT) begin
						if (count_q != 2'd2)
							count_n = count_q + 2'd1;
						if (wc >= 16'd4) begin
							is_entry_n  = 1'b1;
							name_good_n = 1'b0;
							decided_n   = 1'b0;
							char_pos_n  = '0;
						end
					end
				end
			end else begin
				// Operand word; the offset saturates since only 1 and 3+ matter.
				if (is_entry_q) begin
					if (offset_q == 2'd1) begin
						model_n = item.word;
					end else if (offset_q == 2'd3 && !decided_q) begin
						char_pos_n = name_res.char_pos;
						if (name_res.done) begin
							name_good_n = name_res.good;
							decided_n   = 1'b1;
						end
					end
				end
				left_n = left_q - 16'd1;
				if (offset_q != 2'd3)
					offset_n = offset_q + 2'd1;
			end
		end
		if (word_pos_q <= WORD_POS_W'(MAX_WORDS))
			word_pos_n = word_pos_q + 1'b1;
	end

	// Verdict from the state after the final word.
	always_comb begin
		if (word_pos_n < WORD_POS_W'(5) || word_pos_n > WORD_POS_W'(MAX_WORDS) ||
				!magic_n || bad_n || left_n != 16'd0)
			verdict = VERDICT_BAD_MODULE;
		else if (count_n != 2'd1 || !name_good_n)
			verdict = VERDICT_WRONG_ENTRY;
		else if (model_n != cfg.expected_model)
			verdict = VERDICT_WRONG_STAGE;
		else
			verdict = VERDICT_OK;
	end

	// State registers; the final word of a module returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_pos_q  <= '0;
			magic_q     <= 1'b0;
			left_q      <= '0;
			offset_q    <= '0;
			is_entry_q  <= 1'b0;
			char_pos_q  <= '0;
			decided_q   <= 1'b0;
			count_q     <= '0;
			name_good_q <= 1'b0;
			model_q     <= '0;
			bad_q       <= 1'b0;
		end else if (step) begin
			if (item.last) begin
				word_pos_q  <= '0;
				magic_q     <= 1'b0;
				left_q      <= '0;
				offset_q    <= '0;
				is_entry_q  <= 1'b0;
				char_pos_q  <= '0;
				decided_q   <= 1'b0;
				count_q     <= '0;
				name_good_q <= 1'b0;
				model_q     <= '0;
				bad_q       <= 1'b0;
			end else begin
				word_pos_q  <= word_pos_n;
				magic_q     <= magic_n;
				left_q      <= left_n;
				offset_q    <= offset_n;
				is_entry_q  <= is_entry_n;
				char_pos_q  <= char_pos_n;
				decided_q   <= decided_n;
				count_q     <= count_n;
				name_good_q <= name_good_n;
				model_q     <= model_n;
				bad_q       <= bad_n;
			end
		end
	end

	assign stat.at_start    = (word_pos_q == '0);
	assign stat.entry_count = count_q;

endmodule

>>> sv/spirv_entry_point_checker_top.sv
// Top level of the SPIR-V entry point checker: input register, core, result register.
// Depends on spv_ep_pkg, spv_ep_cfg, spv_ep_core and assert_macros.svh.
//
// Channel  Direction  Payload (low bit first)            Moves
// s_*      in         tdata: module_word[31:0]; tlast    one module word per item
// m_*      out        tdata: verdict[1:0], zero padded   one verdict per module
// cfg_*    in         cfg_index[2:0], cfg_data[63:0]     one register write
//
// The core takes one word per step. A word enters every cycle unless a final word
// waits for a held result register; the verdict is valid from the edge that moves
// the final word from the input register through the core into the result register.
// Reset clears the walker, the configuration and both valid flags, not the data registers.
// Only a final word waits while the result register is still held by the output.
`include "assert_macros.svh"

module spirv_entry_point_checker_top import spv_ep_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // module_word[31:0]
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // verdict[1:0], zeros above
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	cfg_t       cfg;
	item_t      item_s1;
	logic       v_s1;
	logic       advance;
	verdict_t   verdict;
	verdict_t   verdict_q;
	logic       out_valid_q;
	core_stat_t core_stat;

	spv_ep_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The held item moves on unless it is a final word facing a full result slot.
	assign advance  = !(item_s1.last && out_valid_q && !m_tready);
	assign s_tready = !v_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.word <= s_tdata;
			item_s1.last <= s_tlast;
		end
	end

	spv_ep_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (v_s1 && advance),
		.item    (item_s1),
		.cfg     (cfg),
		.verdict (verdict),
		.stat    (core_stat)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s1 && advance && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && advance && item_s1.last)
			verdict_q <= verdict;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, verdict_q};

	// A new result only follows a final word leaving the input register.
	`ASSERT_SAME(a_res_from_last, $rose(m_tvalid), $past(v_s1 && item_s1.last), "result without final word")
	// A stalled input register keeps its item.
	`ASSERT_NEXT(a_s1_hold, v_s1 && !advance, v_s1 && $stable(item_s1.word), "held item lost")
	// The walker is back at the module start after a final word.
	`ASSERT_NEXT(a_clear_after_last, v_s1 && advance && item_s1.last, core_stat.at_start, "walker not cleared")
	// The entry point count saturates at two.
	`ASSERT_NEVER(a_count_sat, core_stat.entry_count == 2'd3, "entry count overflow")

endmodule
